FILE: src/sqsp_pkg.sv
// ----------------------------------------------------------------------------
// sqsp_pkg: shared types and constants of the square spiral cell locator
// Widths of the root and the coordinates, pipeline slicing, the per-side
// direction tables and the control struct that travels with each word.
// ----------------------------------------------------------------------------
package sqsp_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 32;

   // 16-step root, top trial bit 0x8000
   localparam int ROOT_BITS  = 16;
   localparam int COORD_WIDTH = 16;
   localparam int SIDE_WIDTH  = 3;
   localparam int SIDE_COUNT  = 8;

   localparam int ROOT_STEPS_PER_STAGE = 2;
   localparam int DIV_STEPS_PER_STAGE  = 4;

   // direction of one unit: zero, plus one or minus one
   typedef enum logic [1:0] {
      UNIT_ZERO  = 2'b00,
      UNIT_PLUS  = 2'b01,
      UNIT_MINUS = 2'b11
   } unit_type;

   typedef unit_type unit_table_type [SIDE_COUNT];

   localparam unit_table_type CORNER_DX = '{
      UNIT_PLUS, UNIT_PLUS, UNIT_ZERO, UNIT_MINUS,
      UNIT_MINUS, UNIT_MINUS, UNIT_ZERO, UNIT_PLUS};
   localparam unit_table_type CORNER_DY = '{
      UNIT_ZERO, UNIT_MINUS, UNIT_MINUS, UNIT_MINUS,
      UNIT_ZERO, UNIT_PLUS, UNIT_PLUS, UNIT_PLUS};
   localparam unit_table_type STEP_DX = '{
      UNIT_ZERO, UNIT_MINUS, UNIT_MINUS, UNIT_ZERO,
      UNIT_ZERO, UNIT_PLUS, UNIT_PLUS, UNIT_ZERO};
   localparam unit_table_type STEP_DY = '{
      UNIT_MINUS, UNIT_ZERO, UNIT_ZERO, UNIT_PLUS,
      UNIT_PLUS, UNIT_ZERO, UNIT_ZERO, UNIT_MINUS};

   // travels with every word down the pipe
   typedef struct packed {
      logic valid;
      logic origin;
   } ctl_type;

endpackage

FILE: src/sqsp_root.sv
// ----------------------------------------------------------------------------
// sqsp_root: pipelined 16-step integer square root
// Takes n, forms n-1 and resolves two root bits per stage; n and the
// control struct travel along with the partial root and remainder.
// ----------------------------------------------------------------------------
module sqsp_root #(
   parameter int NUMBER_WIDTH = sqsp_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sqsp_pkg::ctl_type                in_ctl,
   input  logic [NUMBER_WIDTH-1:0]          in_n,
   output sqsp_pkg::ctl_type                out_ctl,
   output logic [NUMBER_WIDTH-1:0]          out_n,
   output logic [sqsp_pkg::ROOT_BITS-1:0]   out_root
);

   localparam int STEPS  = sqsp_pkg::ROOT_STEPS_PER_STAGE;
   localparam int STAGES = sqsp_pkg::ROOT_BITS / STEPS;
   localparam int RB     = sqsp_pkg::ROOT_BITS;
   localparam int RW     = (NUMBER_WIDTH > 2 * RB + 2) ? NUMBER_WIDTH : 2 * RB + 2;

   sqsp_pkg::ctl_type       ctl_ff [STAGES];
   logic [NUMBER_WIDTH-1:0] n_ff   [STAGES];
   logic [NUMBER_WIDTH-1:0] v_ff   [STAGES];
   logic [RB-1:0]           g_ff   [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      sqsp_pkg::ctl_type       ctl_src;
      logic [NUMBER_WIDTH-1:0] n_src;
      logic [NUMBER_WIDTH-1:0] v_src;
      logic [RB-1:0]           g_src;
      logic [NUMBER_WIDTH-1:0] v_in;
      logic [RB-1:0]           g_in;

      if (i == 0) begin : g_first
         assign ctl_src = in_ctl;
         assign n_src   = in_n;
         assign v_src   = in_n - NUMBER_WIDTH'(1);
         assign g_src   = '0;
      end else begin : g_next
         assign ctl_src = ctl_ff[i-1];
         assign n_src   = n_ff[i-1];
         assign v_src   = v_ff[i-1];
         assign g_src   = g_ff[i-1];
      end

      always_comb begin
         logic [RW-1:0] trial;
         v_in = v_src;
         g_in = g_src;
         for (int j = 0; j < STEPS; j++) begin
            // trial = (2g + bit) * bit, bit = 2^k
            trial = (RW'({g_in, 1'b0}) + (RW'(1) << (RB - 1 - (i * STEPS + j))))
                    << (RB - 1 - (i * STEPS + j));
            if (RW'(v_in) >= trial) begin
               g_in = g_in | (RB'(1) << (RB - 1 - (i * STEPS + j)));
               v_in = NUMBER_WIDTH'(RW'(v_in) - trial);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else begin
            ctl_ff[i] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         n_ff[i] <= n_src;
         v_ff[i] <= v_in;
         g_ff[i] <= g_in;
      end
   end

   assign out_ctl  = ctl_ff[STAGES-1];
   assign out_n    = n_ff[STAGES-1];
   assign out_root = g_ff[STAGES-1];

endmodule

FILE: src/sqsp_divmod.sv
// ----------------------------------------------------------------------------
// sqsp_divmod: pipelined restoring division of the ring position by r
// One quotient bit per step, four steps per stage; the quotient is kept
// saturated at seven, the remainder is the offset along the half side.
// ----------------------------------------------------------------------------
module sqsp_divmod #(
   parameter int NUMBER_WIDTH = sqsp_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sqsp_pkg::ctl_type                  in_ctl,
   input  logic [NUMBER_WIDTH-1:0]            in_pos,
   input  logic [sqsp_pkg::COORD_WIDTH-1:0]   in_r,
   output sqsp_pkg::ctl_type                  out_ctl,
   output logic [sqsp_pkg::SIDE_WIDTH-1:0]    out_side,
   output logic [sqsp_pkg::COORD_WIDTH-1:0]   out_off,
   output logic [sqsp_pkg::COORD_WIDTH-1:0]   out_r
);

   localparam int STEPS  = sqsp_pkg::DIV_STEPS_PER_STAGE;
   localparam int STAGES = (NUMBER_WIDTH + STEPS - 1) / STEPS;
   localparam int CW     = sqsp_pkg::COORD_WIDTH;
   localparam int SW     = sqsp_pkg::SIDE_WIDTH;

   sqsp_pkg::ctl_type       ctl_ff [STAGES];
   logic [NUMBER_WIDTH-1:0] pos_ff [STAGES];
   logic [CW-1:0]           rem_ff [STAGES];
   logic [CW-1:0]           r_ff   [STAGES];
   logic [SW-1:0]           q_ff   [STAGES];
   logic                    big_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      sqsp_pkg::ctl_type       ctl_src;
      logic [NUMBER_WIDTH-1:0] pos_src;
      logic [CW-1:0]           rem_src;
      logic [CW-1:0]           r_src;
      logic [SW-1:0]           q_src;
      logic                    big_src;
      logic [NUMBER_WIDTH-1:0] pos_in;
      logic [CW-1:0]           rem_in;
      logic [SW-1:0]           q_in;
      logic                    big_in;

      if (i == 0) begin : g_first
         assign ctl_src = in_ctl;
         assign pos_src = in_pos;
         assign rem_src = '0;
         assign r_src   = in_r;
         assign q_src   = '0;
         assign big_src = 1'b0;
      end else begin : g_next
         assign ctl_src = ctl_ff[i-1];
         assign pos_src = pos_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign r_src   = r_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign big_src = big_ff[i-1];
      end

      always_comb begin
         logic [CW:0] trial;
         pos_in = pos_src;
         rem_in = rem_src;
         q_in   = q_src;
         big_in = big_src;
         for (int j = 0; j < STEPS; j++) begin
            if (i * STEPS + j < NUMBER_WIDTH) begin
               trial  = {rem_in, pos_in[NUMBER_WIDTH-1]};
               pos_in = pos_in << 1;
               // quotient past seven saturates the side
               big_in = big_in | q_in[SW-1];
               if (trial >= {1'b0, r_src}) begin
                  rem_in = CW'(trial - {1'b0, r_src});
                  q_in   = {q_in[SW-2:0], 1'b1};
               end else begin
                  rem_in = trial[CW-1:0];
                  q_in   = {q_in[SW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else begin
            ctl_ff[i] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         pos_ff[i] <= pos_in;
         rem_ff[i] <= rem_in;
         r_ff[i]   <= r_src;
         q_ff[i]   <= q_in;
         big_ff[i] <= big_in;
      end
   end

   assign out_ctl  = ctl_ff[STAGES-1];
   assign out_side = big_ff[STAGES-1] ? SW'(sqsp_pkg::SIDE_COUNT - 1) : q_ff[STAGES-1];
   assign out_off  = rem_ff[STAGES-1];
   assign out_r    = r_ff[STAGES-1];

endmodule

FILE: src/square_spiral_cell_to_point.sv
// ----------------------------------------------------------------------------
// square_spiral_cell_to_point: square spiral cell number to cell coordinates
//
//   channel   ports                                  handshake
//   request   req_cell_number                        start, busy
//   response  rsp_x_coord, rsp_y_coord               rsp_strobe
//
// One word enters per cycle while busy is low. Path: input register,
// eight root stages, ring, square, position, the divider stages and the
// output register.
// busy is high during reset and the cycle after, low otherwise.
// Reset clears the control structs and the strobe only; the response side takes every word.
// ----------------------------------------------------------------------------
module square_spiral_cell_to_point #(
   parameter int NUMBER_WIDTH = sqsp_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [NUMBER_WIDTH-1:0]           req_cell_number,
   output logic                                     rsp_strobe,
   output logic signed [sqsp_pkg::COORD_WIDTH-1:0]  rsp_x_coord,
   output logic signed [sqsp_pkg::COORD_WIDTH-1:0]  rsp_y_coord
);

   localparam int CW = sqsp_pkg::COORD_WIDTH;
   localparam int RB = sqsp_pkg::ROOT_BITS;
   localparam int SQ = 2 * RB;
   localparam int EW = (NUMBER_WIDTH > SQ) ? NUMBER_WIDTH : SQ;

   function automatic logic [CW-1:0] scale(sqsp_pkg::unit_type u, logic [CW-1:0] v);
      logic [CW-1:0] res;
      unique case (u)
         sqsp_pkg::UNIT_PLUS:  res = v;
         sqsp_pkg::UNIT_MINUS: res = CW'(0) - v;
         default:              res = '0;
      endcase
      return res;
   endfunction

   logic                    busy_ff;
   sqsp_pkg::ctl_type       in_ctl_ff;
   logic [NUMBER_WIDTH-1:0] in_n_ff;

   sqsp_pkg::ctl_type       root_ctl;
   logic [NUMBER_WIDTH-1:0] root_n;
   logic [RB-1:0]           root_s;

   sqsp_pkg::ctl_type       ring_ctl_ff;
   logic [NUMBER_WIDTH-1:0] ring_n_ff;
   logic [CW-1:0]           ring_r_ff;
   logic [RB-1:0]           ring_d_ff;
   logic [RB:0]             ring_sum;

   sqsp_pkg::ctl_type       sq_ctl_ff;
   logic [NUMBER_WIDTH-1:0] sq_n_ff;
   logic [CW-1:0]           sq_r_ff;
   logic [SQ-1:0]           sq_inner_ff;

   sqsp_pkg::ctl_type       pos_ctl_ff;
   logic [NUMBER_WIDTH-1:0] pos_ff;
   logic [CW-1:0]           pos_r_ff;

   sqsp_pkg::ctl_type       div_ctl;
   logic [sqsp_pkg::SIDE_WIDTH-1:0] div_side;
   logic [CW-1:0]           div_off;
   logic [CW-1:0]           div_r;

   logic                    out_strobe_ff;
   logic [CW-1:0]           out_x_ff;
   logic [CW-1:0]           out_x_in;
   logic [CW-1:0]           out_y_ff;
   logic [CW-1:0]           out_y_in;

   logic                    accept;
   logic [NUMBER_WIDTH-1:0] req_n;

   assign accept   = start & ~busy_ff;
   assign busy     = busy_ff;
   assign req_n    = unsigned'(req_cell_number);
   assign ring_sum = {1'b0, root_s} + (RB + 1)'(1);

   // control: valid bits and the busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         in_ctl_ff     <= '0;
         ring_ctl_ff   <= '0;
         sq_ctl_ff     <= '0;
         pos_ctl_ff    <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         busy_ff          <= 1'b0;
         in_ctl_ff.valid  <= accept;
         in_ctl_ff.origin <= req_n[NUMBER_WIDTH-1] | (req_n <= NUMBER_WIDTH'(1));
         ring_ctl_ff      <= root_ctl;
         sq_ctl_ff        <= ring_ctl_ff;
         pos_ctl_ff       <= sq_ctl_ff;
         out_strobe_ff    <= div_ctl.valid;
      end
   end

   sqsp_root #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl_ff),
      .in_n     (in_n_ff),
      .out_ctl  (root_ctl),
      .out_n    (root_n),
      .out_root (root_s)
   );

   // ring r = (s+1)/2, inner side 2r-1; then the square and the position
   always_ff @(posedge clock) begin
      in_n_ff     <= req_n;
      ring_n_ff   <= root_n;
      ring_r_ff   <= ring_sum[RB:1];
      ring_d_ff   <= RB'({ring_sum[RB:1], 1'b0} - (RB + 1)'(1));
      sq_n_ff     <= ring_n_ff;
      sq_r_ff     <= ring_r_ff;
      sq_inner_ff <= SQ'(ring_d_ff) * SQ'(ring_d_ff);
      pos_ff      <= NUMBER_WIDTH'(EW'(sq_n_ff) - EW'(1) - EW'(sq_inner_ff));
      pos_r_ff    <= sq_r_ff;
   end

   sqsp_divmod #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_divmod (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (pos_ctl_ff),
      .in_pos   (pos_ff),
      .in_r     (pos_r_ff),
      .out_ctl  (div_ctl),
      .out_side (div_side),
      .out_off  (div_off),
      .out_r    (div_r)
   );

   // corner of the half side plus the offset along it; origin forces zero
   always_comb begin
      if (div_ctl.origin) begin
         out_x_in = '0;
         out_y_in = '0;
      end else begin
         out_x_in = scale(sqsp_pkg::CORNER_DX[div_side], div_r)
                  + scale(sqsp_pkg::STEP_DX[div_side], div_off);
         out_y_in = scale(sqsp_pkg::CORNER_DY[div_side], div_r)
                  + scale(sqsp_pkg::STEP_DY[div_side], div_off);
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
   end

   assign rsp_strobe  = out_strobe_ff;
   assign rsp_x_coord = signed'(out_x_ff);
   assign rsp_y_coord = signed'(out_y_ff);

endmodule
